// ===== design/ctt_pkg.sv =====
// Shared types and constants for the capacitive touch toggle unit.
package ctt_pkg;

  localparam int SAMPLE_BITS = 8;
  localparam int WINDOW      = 16;
  localparam int WIN_LOG     = $clog2(WINDOW);
  localparam int SLOT_W      = WIN_LOG;
  localparam int SUM_W       = SAMPLE_BITS + WIN_LOG;
  localparam int COUNT_W     = WIN_LOG + 1;
  localparam int THR_W       = 8;

  localparam logic [THR_W-1:0] THRESHOLD_RESET = THR_W'(5);

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_CAL    = 1'b1;

  typedef struct packed {
    logic                   kind;
    logic [SAMPLE_BITS-1:0] charge_count;
  } ctt_in_t;

  typedef struct packed {
    logic                   led_on;
    logic                   touched;
    logic [SAMPLE_BITS-1:0] window_average;
    logic [SAMPLE_BITS-1:0] baseline_level;
    logic                   calibrating;
  } ctt_out_t;

  typedef struct packed {
    logic                   kind;
    logic [SAMPLE_BITS-1:0] sample;
    logic [SLOT_W-1:0]      slot;
  } ctt_op_t;

endpackage

// ===== design/ctt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module ctt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/ctt_update.sv =====
// Read-modify-write stage: window sum, calibration and press/toggle state.
module ctt_update (
  input  logic                            clk,
  input  logic                            rst,
  input  ctt_pkg::ctt_op_t                op,
  input  logic                            commit,
  input  logic [ctt_pkg::SAMPLE_BITS-1:0] ram_rdata,
  input  logic [ctt_pkg::THR_W-1:0]       threshold,
  output ctt_pkg::ctt_out_t               result,
  output logic                            ram_we,
  output logic [ctt_pkg::SLOT_W-1:0]      ram_waddr,
  output logic [ctt_pkg::SAMPLE_BITS-1:0] ram_wdata
);
  import ctt_pkg::*;

  logic [SUM_W-1:0]       ring_sum, ring_sum_next;
  logic [SAMPLE_BITS-1:0] baseline, baseline_next;
  logic [SUM_W-1:0]       cal_acc, cal_acc_next;
  logic [COUNT_W-1:0]     cal_count, cal_count_next;
  logic                   cal_active, cal_active_next;
  logic                   press_latched, press_latched_next;
  logic                   led_state, led_state_next;
  logic                   ring_full, ring_full_next;
  logic [SAMPLE_BITS-1:0] evicted;
  logic [SAMPLE_BITS-1:0] avg;
  logic                   over;
  logic                   is_sample;

  assign is_sample = (op.kind == KIND_SAMPLE);
  assign evicted   = ring_full ? ram_rdata : '0;

  always_comb begin
    ring_sum_next      = ring_sum;
    baseline_next      = baseline;
    cal_acc_next       = cal_acc;
    cal_count_next     = cal_count;
    cal_active_next    = cal_active;
    press_latched_next = press_latched;
    led_state_next     = led_state;
    ring_full_next     = ring_full;

    if (!is_sample) begin
      cal_acc_next    = '0;
      cal_count_next  = '0;
      cal_active_next = 1'b1;
    end else begin
      ring_sum_next = ring_sum - SUM_W'(evicted) + SUM_W'(op.sample);
      if (op.slot == SLOT_W'(WINDOW - 1)) begin
        ring_full_next = 1'b1;
      end
      if (cal_active) begin
        cal_acc_next   = cal_acc + SUM_W'(op.sample);
        cal_count_next = cal_count + COUNT_W'(1);
        if (cal_count_next >= COUNT_W'(WINDOW)) begin
          baseline_next   = cal_acc_next[SUM_W-1:WIN_LOG];
          cal_active_next = 1'b0;
        end
      end
    end

    avg  = ring_sum_next[SUM_W-1:WIN_LOG];
    over = !cal_active_next &&
           ({1'b0, avg} > ({1'b0, baseline_next} + (SAMPLE_BITS + 1)'(threshold)));

    if (!cal_active_next && is_sample) begin
      if (over) begin
        if (!press_latched) begin
          led_state_next     = !led_state;
          press_latched_next = 1'b1;
        end
      end else begin
        press_latched_next = 1'b0;
      end
    end
  end

  assign result.led_on         = led_state_next;
  assign result.touched        = over;
  assign result.window_average = avg;
  assign result.baseline_level = baseline_next;
  assign result.calibrating    = cal_active_next;

  assign ram_we    = commit && is_sample;
  assign ram_waddr = op.slot;
  assign ram_wdata = op.sample;

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_sum      <= '0;
      baseline      <= '0;
      cal_acc       <= '0;
      cal_count     <= '0;
      cal_active    <= 1'b0;
      press_latched <= 1'b0;
      led_state     <= 1'b0;
      ring_full     <= 1'b0;
    end else if (commit) begin
      ring_sum      <= ring_sum_next;
      baseline      <= baseline_next;
      cal_acc       <= cal_acc_next;
      cal_count     <= cal_count_next;
      cal_active    <= cal_active_next;
      press_latched <= press_latched_next;
      led_state     <= led_state_next;
      ring_full     <= ring_full_next;
    end
  end

endmodule

// ===== design/capacitive_touch_toggle_unit.sv =====
// Capacitive touch toggle unit: top level with ring memory, pipeline control and output register.
// Takes one beat per clock cycle while the output is not stalled. A beat is a charge-time
// sample or a calibration request; each gives one result beat: on acceptance a sample reads
// its evicted entry from the 16-entry ring memory, and when the beat advances the running
// window sum, calibration and LED state are updated and the output register loaded. The ring
// reads as all zero after reset through a fill mark, so no clearing pass is needed and input
// is taken from the first cycle after reset. The touch threshold register resets to 5; the user
// must write it through cfg_we/cfg_data only while no beat is in flight; the block does not enforce this.
module capacitive_touch_toggle_unit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  ctt_pkg::ctt_in_t           in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output ctt_pkg::ctt_out_t          out_data,
  input  logic                       cfg_we,
  input  logic [ctt_pkg::THR_W-1:0]  cfg_data
);
  import ctt_pkg::*;

  logic [THR_W-1:0]       threshold;
  logic [SLOT_W-1:0]      write_slot;
  logic                   s1_valid;
  ctt_op_t                s1_op;
  logic                   accept;
  logic                   advance;
  logic                   rd_en;
  logic [SAMPLE_BITS-1:0] ram_rdata;
  logic                   ram_we;
  logic [SLOT_W-1:0]      ram_waddr;
  logic [SAMPLE_BITS-1:0] ram_wdata;
  ctt_out_t               result;

  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !advance;
  assign accept   = in_valid && !in_stall;
  assign rd_en    = accept && (in_data.kind == KIND_SAMPLE);

  ctt_ram #(
    .WIDTH(SAMPLE_BITS),
    .DEPTH(WINDOW)
  ) u_ring (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (rd_en),
    .raddr(write_slot),
    .rdata(ram_rdata)
  );

  ctt_update u_update (
    .clk      (clk),
    .rst      (rst),
    .op       (s1_op),
    .commit   (advance),
    .ram_rdata(ram_rdata),
    .threshold(threshold),
    .result   (result),
    .ram_we   (ram_we),
    .ram_waddr(ram_waddr),
    .ram_wdata(ram_wdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THRESHOLD_RESET;
    end else if (cfg_we) begin
      threshold <= cfg_data;
    end
  end

  // advance the ring slot at acceptance so the next sample reads the following entry
  always_ff @(posedge clk) begin
    if (rst) begin
      write_slot <= '0;
    end else if (rd_en) begin
      write_slot <= write_slot + SLOT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op.kind   <= in_data.kind;
      s1_op.sample <= in_data.charge_count;
      s1_op.slot   <= write_slot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= result;
    end
  end

endmodule

// ===== design/ctt_checker.sv =====
// Port-level checker for the capacitive touch toggle unit and its bind.
module ctt_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_stall,
  input logic                      out_valid,
  input logic                      out_stall,
  input ctt_pkg::ctt_out_t         out_data
);
  import ctt_pkg::*;

  logic out_beat;
  assign out_beat = out_valid && !out_stall;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result beat changed");

  a_ready_after_reset: assert property (@(posedge clk)
    rst |=> !in_stall && !out_valid)
    else $error("block not empty after reset");

  a_cal_no_touch: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.calibrating |-> !out_data.touched)
    else $error("touch reported during calibration");

  a_toggle_on_touch: assert property (@(posedge clk) disable iff (rst)
    out_beat && $past(out_beat) && (out_data.led_on != $past(out_data.led_on))
      |-> out_data.touched)
    else $error("LED toggled without a touch");

endmodule

bind capacitive_touch_toggle_unit ctt_checker u_ctt_checker (.*);
